// ===== rtl/uart_rx_tx_ring_buffers_unit_defines.svh =====
`ifndef UART_RX_TX_RING_BUFFERS_UNIT_DEFINES_SVH
`define UART_RX_TX_RING_BUFFERS_UNIT_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define URB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the block clock and reset.
`define URB_ASSERT(label, prop, msg) \
    `URB_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/uartrb_pkg.sv =====
`timescale 1ns / 1ps

package uartrb_pkg;

    // item kinds
    localparam logic [1:0] KIND_HOST_RD = 2'd0;
    localparam logic [1:0] KIND_HOST_WR = 2'd1;
    localparam logic [1:0] KIND_LINE    = 2'd2;

    // line status bit positions
    localparam int ST_RX_READY = 0;
    localparam int ST_OVERRUN  = 1;
    localparam int ST_TX_EMPTY = 2;

    // per-beat decision, everything but the popped byte
    typedef struct packed {
        logic       ok;
        logic       send;
        logic       dropped;
        logic       cleared;
        logic       rd_rx;
        logic       irq;
        logic [7:0] rx_count;
        logic [7:0] tx_count;
    } t_item_res;

    // one ring memory access
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_req;

endpackage

// ===== rtl/uartrb_in_if.sv =====
`timescale 1ns / 1ps

interface uartrb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_in;
    logic [2:0] line_status;

    modport source (output valid, kind, data_in, line_status, input ready);
    modport sink   (input valid, kind, data_in, line_status, output ready);
endinterface

// ===== rtl/uartrb_out_if.sv =====
`timescale 1ns / 1ps

interface uartrb_out_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] byte_out;
    logic       send_valid;
    logic       rx_dropped;
    logic       rings_cleared;
    logic       tx_irq_enable;
    logic [7:0] rx_count;
    logic [7:0] tx_count;

    modport source (output valid, ok, byte_out, send_valid, rx_dropped, rings_cleared,
                    tx_irq_enable, rx_count, tx_count, input ready);
    modport sink   (input valid, ok, byte_out, send_valid, rx_dropped, rings_cleared,
                    tx_irq_enable, rx_count, tx_count, output ready);
endinterface

// ===== rtl/uartrb_ram.sv =====
`timescale 1ns / 1ps

// Byte ring storage: one write port, one read port, registered read data.
module uartrb_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/uartrb_ctrl.sv =====
`timescale 1ns / 1ps

// Ring pointers, interrupt enable and per-beat decisions.
module uartrb_ctrl #(
    parameter int QUEUE_DEPTH = 256,
    parameter int PW          = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [1:0]            i_kind,
    input  logic [2:0]            i_line_status,
    output uartrb_pkg::t_item_res o_res,
    output uartrb_pkg::t_mem_req  o_rx_req,
    output uartrb_pkg::t_mem_req  o_tx_req,
    output logic [PW-1:0]         o_rx_waddr,
    output logic [PW-1:0]         o_rx_raddr,
    output logic [PW-1:0]         o_tx_waddr,
    output logic [PW-1:0]         o_tx_raddr
);

    localparam logic [PW:0] DEPTH_W = (PW+1)'(QUEUE_DEPTH);

    logic [PW-1:0] r_rx_wp, r_rx_rp, r_tx_wp, r_tx_rp;
    logic [PW-1:0] n_rx_wp, n_rx_rp, n_tx_wp, n_tx_rp;
    logic          r_irq, n_irq;
    logic [PW-1:0] rx_wnext, rx_rnext, tx_wnext, tx_rnext;
    logic          rx_empty, rx_full, tx_empty, tx_full;
    uartrb_pkg::t_item_res res;
    uartrb_pkg::t_mem_req  rx_req, tx_req;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        logic [PW:0] inc;
        inc = {1'b0, p} + {{PW{1'b0}}, 1'b1};
        return (inc >= DEPTH_W) ? '0 : inc[PW-1:0];
    endfunction

    // fill level, low byte only
    function automatic logic [7:0] f_fill(input logic [PW-1:0] wp, input logic [PW-1:0] rp);
        logic [PW:0]   d;
        logic [PW+7:0] ext;
        if (wp >= rp) begin
            d = {1'b0, wp} - {1'b0, rp};
        end else begin
            d = {1'b0, wp} + DEPTH_W - {1'b0, rp};
        end
        ext = {7'b0, d};
        return ext[7:0];
    endfunction

    assign rx_wnext = f_next(r_rx_wp);
    assign rx_rnext = f_next(r_rx_rp);
    assign tx_wnext = f_next(r_tx_wp);
    assign tx_rnext = f_next(r_tx_rp);
    assign rx_empty = (r_rx_wp == r_rx_rp);
    assign tx_empty = (r_tx_wp == r_tx_rp);
    assign rx_full  = (rx_wnext == r_rx_rp);
    assign tx_full  = (tx_wnext == r_tx_rp);

    always_comb begin
        n_rx_wp = r_rx_wp;
        n_rx_rp = r_rx_rp;
        n_tx_wp = r_tx_wp;
        n_tx_rp = r_tx_rp;
        n_irq   = r_irq;
        res     = '0;
        rx_req  = '0;
        tx_req  = '0;
        case (i_kind)
            uartrb_pkg::KIND_HOST_RD: begin
                if (!rx_empty) begin
                    rx_req.re = 1'b1;
                    res.rd_rx = 1'b1;
                    res.ok    = 1'b1;
                    n_rx_rp   = rx_rnext;
                end
            end
            uartrb_pkg::KIND_HOST_WR: begin
                if (!tx_full) begin
                    tx_req.we = 1'b1;
                    res.ok    = 1'b1;
                    n_tx_wp   = tx_wnext;
                    n_irq     = 1'b1;
                end
            end
            uartrb_pkg::KIND_LINE: begin
                if (i_line_status[uartrb_pkg::ST_RX_READY]) begin
                    if (!i_line_status[uartrb_pkg::ST_OVERRUN] && !rx_full) begin
                        rx_req.we = 1'b1;
                        res.ok    = 1'b1;
                        n_rx_wp   = rx_wnext;
                    end else begin
                        res.dropped = 1'b1;
                    end
                end else if (i_line_status[uartrb_pkg::ST_OVERRUN]) begin
                    // byte discarded, nothing changes
                end else if (i_line_status[uartrb_pkg::ST_TX_EMPTY]) begin
                    if (!tx_empty) begin
                        tx_req.re = 1'b1;
                        res.send  = 1'b1;
                        res.ok    = 1'b1;
                        n_tx_rp   = tx_rnext;
                    end else begin
                        n_irq = 1'b0;
                    end
                end else begin
                    // no status bit: empty both rings
                    n_rx_wp     = '0;
                    n_rx_rp     = '0;
                    n_tx_wp     = '0;
                    n_tx_rp     = '0;
                    n_irq       = 1'b0;
                    res.cleared = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.irq      = n_irq;
        res.rx_count = f_fill(n_rx_wp, n_rx_rp);
        res.tx_count = f_fill(n_tx_wp, n_tx_rp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wp <= '0;
            r_rx_rp <= '0;
            r_tx_wp <= '0;
            r_tx_rp <= '0;
            r_irq   <= 1'b0;
        end else if (i_go) begin
            r_rx_wp <= n_rx_wp;
            r_rx_rp <= n_rx_rp;
            r_tx_wp <= n_tx_wp;
            r_tx_rp <= n_tx_rp;
            r_irq   <= n_irq;
        end
    end

    assign o_res      = res;
    assign o_rx_req   = '{we: rx_req.we & i_go, re: rx_req.re & i_go};
    assign o_tx_req   = '{we: tx_req.we & i_go, re: tx_req.re & i_go};
    assign o_rx_waddr = r_rx_wp;
    assign o_rx_raddr = r_rx_rp;
    assign o_tx_waddr = r_tx_wp;
    assign o_tx_raddr = r_tx_rp;

endmodule

// ===== rtl/uart_rx_tx_ring_buffers_unit.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted input beat passes through stage 1 and then the output register.
// Throughput: one beat per cycle while the receiver keeps o_out.ready high; pointers update at
// accept, bytes are read from the ring memories at accept and reach stage 1 through their registered read port.
// Reset: synchronous, active low; clears pointers, transmit interrupt enable and
// beat valids. Ring memories are not cleared and need no clearing pass.

`include "uart_rx_tx_ring_buffers_unit_defines.svh"

module uart_rx_tx_ring_buffers_unit #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    uartrb_in_if.sink           i_in,
    uartrb_out_if.source        o_out
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    // accept stage feeds the memory read; stage 1 waits for read data
    logic                  go;
    logic                  s1_move;
    uartrb_pkg::t_item_res res;
    uartrb_pkg::t_mem_req  rx_req, tx_req;
    logic [PW-1:0]         rx_waddr, rx_raddr, tx_waddr, tx_raddr;
    logic [7:0]            rx_rdata, tx_rdata;
    logic [7:0]            n_byte;

    logic                  r_s1_valid;
    uartrb_pkg::t_item_res r_s1;

    // output register
    logic                  r_out_valid;
    uartrb_pkg::t_item_res r_out;
    logic [7:0]            r_out_byte;

    // stage 1 advances when the output register is free or being drained
    assign s1_move    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_move;
    assign go         = i_in.valid && i_in.ready;

    uartrb_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PW          (PW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (go),
        .i_kind        (i_in.kind),
        .i_line_status (i_in.line_status),
        .o_res         (res),
        .o_rx_req      (rx_req),
        .o_tx_req      (tx_req),
        .o_rx_waddr    (rx_waddr),
        .o_rx_raddr    (rx_raddr),
        .o_tx_waddr    (tx_waddr),
        .o_tx_raddr    (tx_raddr)
    );

    // Receive ring: written by line events, read by host reads.
    uartrb_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PW)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_req.we),
        .i_waddr (rx_waddr),
        .i_wdata (i_in.data_in),
        .i_re    (rx_req.re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    // Transmit ring: written by host writes, read on transmitter empty.
    uartrb_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PW)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_req.we),
        .i_waddr (tx_waddr),
        .i_wdata (i_in.data_in),
        .i_re    (tx_req.re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    // A read only targets a slot written by an earlier beat, and the read
    // data register holds while stage 1 is stalled (no new read is issued).
    always_comb begin
        if (r_s1.rd_rx) begin
            n_byte = rx_rdata;
        end else if (r_s1.send) begin
            n_byte = tx_rdata;
        end else begin
            n_byte = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= go;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1 <= res;
        end
        if (s1_move && r_s1_valid) begin
            r_out      <= r_s1;
            r_out_byte <= n_byte;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.ok            = r_out.ok;
    assign o_out.byte_out      = r_out_byte;
    assign o_out.send_valid    = r_out.send;
    assign o_out.rx_dropped    = r_out.dropped;
    assign o_out.rings_cleared = r_out.cleared;
    assign o_out.tx_irq_enable = r_out.irq;
    assign o_out.rx_count      = r_out.rx_count;
    assign o_out.tx_count      = r_out.tx_count;

    `URB_ASSERT(a_stall_blocks, r_s1_valid && r_out_valid && !o_out.ready |-> !i_in.ready, "input taken while stage 1 is stuck")
    `URB_ASSERT(a_accept_lands, go |=> r_s1_valid, "accepted beat did not reach stage 1")
    `URB_ASSERT(a_clear_empty, o_out.valid && o_out.rings_cleared |-> (o_out.rx_count == 8'd0) && (o_out.tx_count == 8'd0) && !o_out.tx_irq_enable, "clear left data or interrupt")
    `URB_ASSERT(a_send_ok, o_out.valid && o_out.send_valid |-> o_out.ok && !o_out.rx_dropped, "send without ok")

endmodule

// ===== dv/uart_rx_tx_ring_buffers_unit_test.sv =====
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers_unit_test;

    localparam int QUEUE_DEPTH = 256;
    localparam int IDLE_PCT    = 28;       // chance in 100 that a side idles in a cycle
    localparam int RAND_BEATS  = 1750;     // random beats that the block acts on
    localparam int HOLD_CYCLES = 400;      // long receiver stall, fills the pipe
    localparam int HOLD_AT     = 500;      // input beats taken before that stall starts
    localparam int CALM_FROM   = 1000;     // window of input beats with no idling at all
    localparam int CALM_TO     = 1300;
    localparam int CYCLE_LIMIT = 100000;

    // kind 3 is not decoded by the block; it must leave all state alone
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // line status values built from the package bit positions
    localparam logic [2:0] LS_NONE  = 3'b000;
    localparam logic [2:0] LS_RX    = 3'b001 << uartrb_pkg::ST_RX_READY;
    localparam logic [2:0] LS_OVR   = 3'b001 << uartrb_pkg::ST_OVERRUN;
    localparam logic [2:0] LS_TXE   = 3'b001 << uartrb_pkg::ST_TX_EMPTY;

    // traffic shape of one random segment
    typedef enum logic [2:0] {
        FILL_RX,
        FILL_TX,
        MIXED,
        DRAIN_RX,
        DRAIN_TX
    } t_traffic;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] status;
    } t_port_beat;

    typedef struct packed {
        logic       ok;
        logic [7:0] byte_out;
        logic       send;
        logic       dropped;
        logic       cleared;
        logic       irq;
        logic [7:0] rx_count;
        logic [7:0] tx_count;
    } t_ring_outcome;

    logic i_clk;
    logic i_rst_n;

    uartrb_in_if  in_if();
    uartrb_out_if out_if();

    uart_rx_tx_ring_buffers_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // pending stimulus and the outcomes still owed by the block
    t_port_beat    beat_q[$];
    t_ring_outcome outcome_q[$];

    int  errors      = 0;
    int  beats_taken = 0;   // input beats accepted, NBA-updated by the driver
    int  total_beats = 0;
    int  cycle_cnt   = 0;
    int  hold_left   = 0;
    bit  held        = 1'b0;
    logic calm;

    assign calm = (beats_taken >= CALM_FROM) && (beats_taken < CALM_TO);

    // shadow of the two rings
    logic [7:0] rx_mem [QUEUE_DEPTH];
    logic [7:0] tx_mem [QUEUE_DEPTH];
    int         rx_wp = 0;
    int         rx_rp = 0;
    int         tx_wp = 0;
    int         tx_rp = 0;
    logic       tx_irq = 1'b0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int ring_inc(int p);
        return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic logic [7:0] ring_level(int wp, int rp);
        int lvl;
        lvl = (wp >= rp) ? wp - rp : wp + QUEUE_DEPTH - rp;
        return lvl[7:0];
    endfunction

    // advances the shadow rings by one beat and returns what the block must report
    function automatic t_ring_outcome ring_step(t_port_beat b);
        t_ring_outcome r;
        int            nxt;
        r = '0;
        case (b.kind)
            uartrb_pkg::KIND_HOST_RD: begin
                if (rx_wp != rx_rp) begin
                    r.byte_out = rx_mem[rx_rp];
                    rx_rp      = ring_inc(rx_rp);
                    r.ok       = 1'b1;
                end
            end
            uartrb_pkg::KIND_HOST_WR: begin
                nxt = ring_inc(tx_wp);
                // full ring: byte ignored, interrupt enable left as it was
                if (nxt != tx_rp) begin
                    tx_mem[tx_wp] = b.data;
                    tx_wp         = nxt;
                    tx_irq        = 1'b1;
                    r.ok          = 1'b1;
                end
            end
            uartrb_pkg::KIND_LINE: begin
                if (b.status[uartrb_pkg::ST_RX_READY]) begin
                    // overrun or no room: byte lost and flagged
                    nxt = ring_inc(rx_wp);
                    if (!b.status[uartrb_pkg::ST_OVERRUN] && nxt != rx_rp) begin
                        rx_mem[rx_wp] = b.data;
                        rx_wp         = nxt;
                        r.ok          = 1'b1;
                    end else begin
                        r.dropped = 1'b1;
                    end
                end else if (b.status[uartrb_pkg::ST_OVERRUN]) begin
                    // overrun alone: byte thrown away, no flag
                end else if (b.status[uartrb_pkg::ST_TX_EMPTY]) begin
                    if (tx_wp != tx_rp) begin
                        r.byte_out = tx_mem[tx_rp];
                        tx_rp      = ring_inc(tx_rp);
                        r.send     = 1'b1;
                        r.ok       = 1'b1;
                    end else begin
                        tx_irq = 1'b0;
                    end
                end else begin
                    // no status bit at all: both rings dropped
                    rx_wp     = 0;
                    rx_rp     = 0;
                    tx_wp     = 0;
                    tx_rp     = 0;
                    tx_irq    = 1'b0;
                    r.cleared = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.irq      = tx_irq;
        r.rx_count = ring_level(rx_wp, rx_rp);
        r.tx_count = ring_level(tx_wp, tx_rp);
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            errors++;
        end
    endfunction

    function automatic t_port_beat make_beat(logic [1:0] kind, logic [7:0] data,
                                             logic [2:0] status);
        t_port_beat b;
        b.kind   = kind;
        b.data   = data;
        b.status = status;
        return b;
    endfunction

    // any decoded beat, never a ring clear
    function automatic t_port_beat any_beat();
        t_port_beat b;
        b.kind   = 2'($urandom_range(2));
        b.data   = 8'($urandom_range(255));
        b.status = 3'($urandom_range(7, 1));
        return b;
    endfunction

    // one random beat, biased by the traffic shape of the segment
    function automatic t_port_beat draw_beat(t_traffic mode);
        t_port_beat b;
        int         roll;
        roll = $urandom_range(99);
        b    = any_beat();
        case (mode)
            FILL_RX: begin
                if (roll < 85) begin
                    b.kind   = uartrb_pkg::KIND_LINE;
                    b.status = $urandom_range(3) == 0 ? (LS_RX | LS_TXE) : LS_RX;
                end else if (roll < 95) begin
                    b.kind = uartrb_pkg::KIND_HOST_RD;
                end
            end
            FILL_TX: begin
                if (roll < 85) begin
                    b.kind = uartrb_pkg::KIND_HOST_WR;
                end else if (roll < 95) begin
                    b.kind   = uartrb_pkg::KIND_LINE;
                    b.status = LS_TXE;
                end
            end
            DRAIN_RX: begin
                if (roll < 85) begin
                    b.kind = uartrb_pkg::KIND_HOST_RD;
                end else if (roll < 95) begin
                    b.kind   = uartrb_pkg::KIND_LINE;
                    b.status = LS_RX;
                end
            end
            DRAIN_TX: begin
                if (roll < 85) begin
                    b.kind   = uartrb_pkg::KIND_LINE;
                    b.status = LS_TXE;
                end else if (roll < 95) begin
                    b.kind = uartrb_pkg::KIND_HOST_WR;
                end
            end
            default: begin
                // mixed traffic: rare clears and rare undecoded kinds
                if (roll < 2) begin
                    b.kind   = uartrb_pkg::KIND_LINE;
                    b.status = LS_NONE;
                end else if (roll < 4) begin
                    b.kind   = KIND_UNUSED;
                    b.status = 3'($urandom_range(7));
                end
            end
        endcase
        return b;
    endfunction

    // driver: takes beats from beat_q, predicts each one at the edge it is taken
    t_port_beat cur_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.kind        <= uartrb_pkg::KIND_HOST_RD;
            in_if.data_in     <= 8'd0;
            in_if.line_status <= LS_NONE;
        end else begin
            if (in_if.valid && in_if.ready) begin
                outcome_q.push_back(ring_step(cur_beat));
                beats_taken <= beats_taken + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (beat_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    cur_beat          = beat_q.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.kind        <= cur_beat.kind;
                    in_if.data_in     <= cur_beat.data;
                    in_if.line_status <= cur_beat.status;
                end else begin
                    // idle: payload is noise the block must not look at
                    in_if.valid       <= 1'b0;
                    in_if.kind        <= 2'($urandom_range(3));
                    in_if.data_in     <= 8'($urandom_range(255));
                    in_if.line_status <= 3'($urandom_range(7));
                end
            end
        end
    end

    // receiver ready: random stalls, plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (!held && beats_taken >= HOLD_AT) begin
            held         <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: every result beat against the oldest outcome owed
    t_ring_outcome want;

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result beat with nothing owed: expected none, actual ok=%0d byte=%0d",
                         $time, out_if.ok, out_if.byte_out);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                check_field("ok",            8'(want.ok),      8'(out_if.ok));
                check_field("byte_out",      want.byte_out,    out_if.byte_out);
                check_field("send_valid",    8'(want.send),    8'(out_if.send_valid));
                check_field("rx_dropped",    8'(want.dropped), 8'(out_if.rx_dropped));
                check_field("rings_cleared", 8'(want.cleared), 8'(out_if.rings_cleared));
                check_field("tx_irq_enable", 8'(want.irq),     8'(out_if.tx_irq_enable));
                check_field("rx_count",      want.rx_count,    out_if.rx_count);
                check_field("tx_count",      want.tx_count,    out_if.tx_count);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int         n;
        int         seg_len;
        int         seg;
        t_traffic   mode;
        t_port_beat b;

        i_rst_n = 1'b0;

        // directed: each path but the full-ring ones, byte extremes, all status combinations
        beat_q.push_back(make_beat(uartrb_pkg::KIND_HOST_RD, 8'h00, LS_NONE)); // read, empty rx
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h00, LS_TXE));  // tx empty, no bytes
        beat_q.push_back(make_beat(uartrb_pkg::KIND_HOST_WR, 8'h00, LS_NONE));
        beat_q.push_back(make_beat(uartrb_pkg::KIND_HOST_WR, 8'hFF, 3'b111));
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h00, LS_TXE));  // sends 0x00
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'hFF, LS_TXE));  // sends 0xFF
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h55, LS_TXE));  // irq off
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'hFF, LS_RX));
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h00, LS_RX));
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'hA5, LS_RX | LS_OVR));  // dropped
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h5A, LS_OVR));  // discarded
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h5A, LS_OVR | LS_TXE)); // overrun wins
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h3C, LS_RX | LS_TXE));  // rx wins
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'hC3, 3'b111));  // dropped
        beat_q.push_back(make_beat(uartrb_pkg::KIND_HOST_RD, 8'hFF, 3'b111));
        beat_q.push_back(make_beat(uartrb_pkg::KIND_HOST_RD, 8'h00, LS_NONE));
        beat_q.push_back(make_beat(uartrb_pkg::KIND_HOST_RD, 8'h00, LS_NONE));
        beat_q.push_back(make_beat(uartrb_pkg::KIND_HOST_RD, 8'h00, LS_NONE)); // empty again
        beat_q.push_back(make_beat(uartrb_pkg::KIND_HOST_WR, 8'h81, LS_NONE));
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h7E, LS_RX));
        beat_q.push_back(make_beat(KIND_UNUSED,              8'hFF, 3'b111));  // no effect
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h00, LS_NONE)); // clears both rings
        beat_q.push_back(make_beat(uartrb_pkg::KIND_HOST_RD, 8'h00, LS_NONE));
        beat_q.push_back(make_beat(uartrb_pkg::KIND_LINE,    8'h00, LS_TXE));

        // random: segments walk fill, mix and drain so both rings reach full and empty
        n   = 0;
        seg = 0;
        while (n < RAND_BEATS) begin
            mode = t_traffic'(seg % 5);
            case (mode)
                FILL_RX, FILL_TX: seg_len = $urandom_range(420, 300);
                MIXED:            seg_len = $urandom_range(150, 40);
                default:          seg_len = $urandom_range(350, 150);
            endcase
            for (int k = 0; k < seg_len && n < RAND_BEATS; k++) begin
                b = draw_beat(mode);
                beat_q.push_back(b);
                if (b.kind != KIND_UNUSED) begin
                    n++;
                end
            end
            seg++;
        end
        total_beats = beat_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < total_beats) @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
        // the pipe holds stage 1 and the output register; the extra wait catches any stray result beat
        repeat (6) @(posedge i_clk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
